// ===== sv/rstm_pkg.sv =====
// Shared types, constants, template ROM and helper functions of the record schema matcher.
package rstm_pkg;

	// Default sizes handed to the top level.
	localparam int unsigned NUM_TEMPLATES_DEF = 8;
	localparam int unsigned MAX_COLUMNS_DEF   = 64;

	// Template ROM geometry: sixteen slots, the longest template has 34 columns.
	localparam int unsigned ROM_SLOTS = 16;
	localparam int unsigned ROM_CHARS = 34;
	localparam int unsigned SLOT_W    = 4;

	// Field widths.
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned SCORE_W = 6;
	localparam int unsigned INDEX_W = 3;
	localparam int unsigned POS_W   = 7;

	// Column storage kinds.
	localparam logic [KIND_W-1:0] KIND_NULL = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INT  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_REAL = 3'd2;
	localparam logic [KIND_W-1:0] KIND_TEXT = 3'd3;

	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

	// Configuration port.
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam logic        REG_MIN_SCORE = 1'b0;
	localparam logic [SCORE_W-1:0] MIN_SCORE_RST = 6'd2;

	// Class characters as they appear in the ROM text.
	localparam logic [7:0] CH_INT = "I";
	localparam logic [7:0] CH_TXT = "T";
	localparam logic [7:0] CH_NUM = "N";

	typedef enum logic [1:0] {
		CLS_ANY,
		CLS_INT,
		CLS_TXT,
		CLS_NUM
	} cls_t;

	// Each template is written first column leftmost; unused slots are empty.
	localparam logic [8*ROM_CHARS-1:0] ROM_TEXT [ROM_SLOTS] = '{
		"IITAIIAIAITAA",
		"ITIIIA",
		"ITT",
		"ATTAIIAAATAAAAAIIIIAT",
		"IIIIIITTITTITIIIIIIIITITIIITIIIIII",
		"ITTIIIIAA",
		"ITITTAIIIAAAAT",
		"ITITAATIAAAAAAAAAAAAAAAAA",
		'0, '0, '0, '0, '0, '0, '0, '0
	};

	localparam logic [5:0] ROM_LEN [ROM_SLOTS] = '{
		6'd13, 6'd6, 6'd3, 6'd21, 6'd34, 6'd9, 6'd14, 6'd25,
		6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0
	};

	typedef struct packed {
		logic [KIND_W-1:0] value_kind;
		logic              printable_text;
		logic              last_column;
	} item_t;

	typedef struct packed {
		logic               recognized;
		logic [INDEX_W-1:0] template_index;
		logic [SCORE_W-1:0] top_score;
	} result_t;

	// Broadcast from the top level to every template lane.
	typedef struct packed {
		logic              go;
		logic              last;
		logic [KIND_W-1:0] kind;
		logic              printable;
		logic [POS_W-1:0]  pos;
	} step_t;

	// What a lane reports about the record once its final column has been applied.
	typedef struct packed {
		logic               cand;
		logic               textok;
		logic [SCORE_W-1:0] score;
	} lane_res_t;

	// Node of the winner tree.
	typedef struct packed {
		logic               found;
		logic               tie;
		logic               textok;
		logic [SLOT_W-1:0]  idx;
		logic [SCORE_W-1:0] score;
	} node_t;

	function automatic cls_t class_at(input logic [SLOT_W-1:0] slot, input logic [POS_W-1:0] pos);
		logic [5:0] len;
		logic [5:0] off;
		logic [7:0] ch;
		cls_t       c;
		len = ROM_LEN[slot];
		ch  = 8'h00;
		off = '0;
		if (pos < {1'b0, len}) begin
			off = 6'(len - 6'd1 - pos[5:0]);
			ch  = ROM_TEXT[slot][{off, 3'b000} +: 8];
		end
		case (ch)
			CH_INT:  c = CLS_INT;
			CH_TXT:  c = CLS_TXT;
			CH_NUM:  c = CLS_NUM;
			default: c = CLS_ANY;
		endcase
		return c;
	endfunction

	function automatic logic has_text_col(input logic [SLOT_W-1:0] slot);
		logic r;
		r = 1'b0;
		for (int i = 0; i < ROM_CHARS; i++) begin
			if (ROM_TEXT[slot][8*i +: 8] == CH_TXT) begin
				r = 1'b1;
			end
		end
		return r;
	endfunction

	// Keeps the higher score; equal scores of two found nodes mark a tie.
	function automatic node_t merge(input node_t a, input node_t b);
		node_t r;
		if (!a.found) begin
			r = b;
		end else if (!b.found) begin
			r = a;
		end else if (a.score > b.score) begin
			r = a;
		end else if (b.score > a.score) begin
			r = b;
		end else begin
			r     = a;
			r.tie = 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== sv/rstm_lane.sv =====
// One template lane: alive flag, constrained match count and printable-text flag.
module rstm_lane #(
	parameter int unsigned SLOT = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rstm_pkg::step_t     step,
	output rstm_pkg::lane_res_t res
);

	localparam logic [5:0] LEN      = rstm_pkg::ROM_LEN[SLOT];
	localparam logic       HAS_TEXT = rstm_pkg::has_text_col(rstm_pkg::SLOT_W'(SLOT));

	logic                         alive_q;
	logic                         seen_q;
	logic [rstm_pkg::SCORE_W-1:0] cnt_q;

	logic                         alive_n;
	logic                         seen_n;
	logic [rstm_pkg::SCORE_W-1:0] cnt_n;
	logic                         fits;
	logic                         in_len;
	logic                         ends_here;
	logic                         kind_nz;
	rstm_pkg::cls_t               cls;

	always_comb begin
		cls       = rstm_pkg::class_at(rstm_pkg::SLOT_W'(SLOT), step.pos);
		kind_nz   = step.kind != rstm_pkg::KIND_NULL;
		in_len    = step.pos < {1'b0, LEN};
		ends_here = (8'(step.pos) + 8'd1) == {2'b00, LEN};
		case (cls)
			rstm_pkg::CLS_ANY: fits = 1'b1;
			rstm_pkg::CLS_INT: fits = step.kind == rstm_pkg::KIND_INT;
			rstm_pkg::CLS_TXT: fits = step.kind == rstm_pkg::KIND_TEXT;
			rstm_pkg::CLS_NUM: fits = (step.kind == rstm_pkg::KIND_INT) ||
				(step.kind == rstm_pkg::KIND_REAL);
			default:           fits = 1'b0;
		endcase
		alive_n = alive_q && in_len && (fits || !kind_nz);
		cnt_n   = cnt_q;
		seen_n  = seen_q;
		if (alive_n && kind_nz) begin
			if (cls != rstm_pkg::CLS_ANY && cnt_q != rstm_pkg::SCORE_MAX) begin
				cnt_n = cnt_q + 1'b1;
			end
			if (cls == rstm_pkg::CLS_TXT && step.printable) begin
				seen_n = 1'b1;
			end
		end
	end

	always_comb begin
		res.cand   = alive_n && ends_here;
		res.textok = !HAS_TEXT || seen_n;
		res.score  = cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= 1'b1;
			seen_q  <= 1'b0;
			cnt_q   <= '0;
		end else if (step.go) begin
			if (step.last) begin
				alive_q <= 1'b1;
				seen_q  <= 1'b0;
				cnt_q   <= '0;
			end else begin
				alive_q <= alive_n;
				seen_q  <= seen_n;
				cnt_q   <= cnt_n;
			end
		end
	end

endmodule

// ===== sv/record_schema_template_matcher.sv =====
// Top level of the record schema matcher: column input, template lanes, winner pick and APB register.
//
// The block takes one column of a decoded record per transaction and can take a new column in
// every clock cycle while the input does not stall. Each column is first registered, then it
// updates all template lanes at once (one lane per template, each a few compares and a 6-bit
// increment). On the final column the lanes hand a snapshot of their per-template scores to a
// second stage and clear themselves, so the first column of the next record may follow straight
// away. The second stage picks the unique best template with a small compare tree, applies the
// score floor and the printable-text check, and loads the result register. A result transaction
// therefore becomes valid once the final column of its record has passed the stage 1 register,
// the snapshot stage and the result register, and exactly one result is produced per record. The
// output register and the snapshot stage decouple the two sides: while a result waits on stall,
// further columns of the next record are still taken; the input stalls only when a final column
// would need the snapshot stage and that stage cannot move. The single register, min_score at
// byte address 0, should be written only while no record is in flight.
module record_schema_template_matcher #(
	parameter int unsigned NUM_TEMPLATES = rstm_pkg::NUM_TEMPLATES_DEF,
	parameter int unsigned MAX_COLUMNS   = rstm_pkg::MAX_COLUMNS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                item_valid,
	output logic                                item_stall,
	input  rstm_pkg::item_t                     item,

	output logic                                result_valid,
	input  logic                                result_stall,
	output rstm_pkg::result_t                   result,

	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rstm_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [rstm_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [rstm_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	localparam int unsigned COL_W  = $clog2(MAX_COLUMNS + 1);
	localparam int unsigned LEAVES = 2 ** $clog2(NUM_TEMPLATES);

	// Configuration register.
	logic [rstm_pkg::SCORE_W-1:0] min_score_q;
	logic                         reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2] == rstm_pkg::REG_MIN_SCORE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_score_q <= rstm_pkg::MIN_SCORE_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			min_score_q <= pwdata[rstm_pkg::SCORE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = rstm_pkg::APB_DATA_W'(min_score_q);
		end
	end

	// Stage 1: the accepted column is registered here.
	logic            valid_s1;
	rstm_pkg::item_t item_s1;

	// Stage 2: per-template snapshot taken on a final column.
	logic                valid_s2;
	rstm_pkg::lane_res_t snap_s2 [NUM_TEMPLATES];

	// Stage 3: result register.
	logic              valid_s3;
	rstm_pkg::result_t result_s3;

	logic out_free;
	logic s2_free;
	logic s1_go;
	logic s1_free;

	// A column without the final mark produces no result and never waits on later stages.
	assign out_free   = !valid_s3 || !result_stall;
	assign s2_free    = !valid_s2 || out_free;
	assign s1_go      = valid_s1 && (!item_s1.last_column || s2_free);
	assign s1_free    = !valid_s1 || s1_go;
	assign item_stall = !s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			item_s1 <= item;
		end
	end

	// Record-wide state shared by all lanes.
	logic [COL_W-1:0] pos_q;
	logic             any_q;
	logic             any_n;

	assign any_n = any_q || (item_s1.value_kind != rstm_pkg::KIND_NULL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			any_q <= 1'b0;
		end else if (s1_go) begin
			if (item_s1.last_column) begin
				pos_q <= '0;
				any_q <= 1'b0;
			end else begin
				if (pos_q != COL_W'(MAX_COLUMNS)) begin
					pos_q <= pos_q + 1'b1;
				end
				any_q <= any_n;
			end
		end
	end

	rstm_pkg::step_t     step;
	rstm_pkg::lane_res_t lane_res [NUM_TEMPLATES];

	always_comb begin
		step.go        = s1_go;
		step.last      = item_s1.last_column;
		step.kind      = item_s1.value_kind;
		step.printable = item_s1.printable_text;
		step.pos       = rstm_pkg::POS_W'(pos_q);
	end

	for (genvar g = 0; g < NUM_TEMPLATES; g++) begin : g_lane
		rstm_lane #(
			.SLOT(g)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.step  (step),
			.res   (lane_res[g])
		);
	end

	// A record made only of null columns leaves no candidate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_go && item_s1.last_column;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && item_s1.last_column) begin
			for (int t = 0; t < NUM_TEMPLATES; t++) begin
				snap_s2[t] <= '{
					cand:   lane_res[t].cand && any_n,
					textok: lane_res[t].textok,
					score:  lane_res[t].score
				};
			end
		end
	end

	// Winner tree: leaves follow template order, empty leaves pad to a power of two.
	rstm_pkg::node_t leaf [LEAVES];
	rstm_pkg::node_t node [1:2*LEAVES-1];

	for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
		if (g < NUM_TEMPLATES) begin : g_used
			assign leaf[g] = '{
				found:  snap_s2[g].cand,
				tie:    1'b0,
				textok: snap_s2[g].textok,
				idx:    rstm_pkg::SLOT_W'(g),
				score:  snap_s2[g].score
			};
		end else begin : g_pad
			assign leaf[g] = '0;
		end
	end

	logic              win_ok;
	rstm_pkg::result_t win;

	always_comb begin
		for (int i = 0; i < LEAVES; i++) begin
			node[LEAVES + i] = leaf[i];
		end
		for (int i = LEAVES - 1; i >= 1; i--) begin
			node[i] = rstm_pkg::merge(node[2*i], node[2*i + 1]);
		end
		win_ok = node[1].found && !node[1].tie && node[1].textok &&
			(node[1].score >= min_score_q);
		win = '0;
		if (win_ok) begin
			win.recognized     = 1'b1;
			win.template_index = rstm_pkg::INDEX_W'(node[1].idx);
			win.top_score      = node[1].score;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (out_free) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			result_s3 <= win;
		end
	end

	assign result_valid = valid_s3;
	assign result       = result_s3;

endmodule
